// ===== design/delayed_zero_cross_peak_detector_assert.svh =====
// Assertion macros shared by the detector modules.
`ifndef DELAYED_ZERO_CROSS_PEAK_DETECTOR_ASSERT_SVH
`define DELAYED_ZERO_CROSS_PEAK_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition implies property in the same cycle.
`define DZCPD_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// Condition implies property in the next cycle.
`define DZCPD_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`else

`define DZCPD_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define DZCPD_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ===== design/dzcpd_pkg.sv =====
package dzcpd_pkg;

  // Default geometry
  localparam int HISTORY_DEPTH = 64;
  localparam int SAMPLE_BITS   = 16;

  // Width of the tap delay input
  localparam int TAP_BITS = 6;

  // Event codes reported per sample
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_UP     = 3'd1,
    EV_DOWN   = 3'd2,
    EV_PEAK   = 3'd3,
    EV_TROUGH = 3'd4
  } event_t;

  // Pending crossing direction
  typedef enum logic [1:0] {
    XM_NONE = 2'd0,
    XM_UP   = 2'd1,
    XM_DOWN = 2'd2
  } xmem_t;

endpackage

// ===== design/dzcpd_cell.sv =====
module dzcpd_cell #(
  parameter int SampleBits = dzcpd_pkg::SAMPLE_BITS,
  parameter int IdxW       = 6,
  parameter int CellIndex  = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift,
  input  logic signed [SampleBits-1:0] din,
  input  logic        [IdxW-1:0]       tap_sel,
  output logic signed [SampleBits-1:0] q,
  output logic signed [SampleBits-1:0] cur_part,
  output logic signed [SampleBits-1:0] old_part
);

  localparam logic [IdxW-1:0] MyIdx   = IdxW'(CellIndex);
  localparam logic [IdxW-1:0] PrevIdx = IdxW'((CellIndex > 0) ? CellIndex - 1 : 0);
  localparam logic            HasPrev = (CellIndex > 0);

  // Hold one history sample, take the neighbor's on a push
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= din;
    end
  end

  // Drive this cell's value onto the tap buses when selected
  assign cur_part = (tap_sel == MyIdx) ? q : '0;
  assign old_part = (HasPrev && (tap_sel == PrevIdx)) ? q : '0;

endmodule

// ===== design/dzcpd_classify.sv =====
`include "delayed_zero_cross_peak_detector_assert.svh"

module dzcpd_classify #(
  parameter int SampleBits = dzcpd_pkg::SAMPLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         tap_valid,
  output logic                         tap_ready,
  input  logic signed [SampleBits-1:0] cur_tap,
  input  logic signed [SampleBits-1:0] old_tap,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic        [2:0]            event_res,
  output logic signed [SampleBits-1:0] delayed_sample,
  output logic signed [SampleBits-1:0] last_peak,
  output logic signed [SampleBits-1:0] last_trough
);

  dzcpd_pkg::xmem_t            xmem;
  dzcpd_pkg::xmem_t            xmem_next;
  dzcpd_pkg::event_t           ev;
  dzcpd_pkg::event_t           ev_next;
  logic signed [SampleBits-1:0] peak_value;
  logic signed [SampleBits-1:0] peak_next;
  logic signed [SampleBits-1:0] trough_value;
  logic signed [SampleBits-1:0] trough_next;
  logic                         take;

  // Output register frees up when empty or when its transfer completes
  assign tap_ready = !out_valid || !out_stall;
  assign take      = tap_valid && tap_ready;

  // Classify the tap pair, first matching rule wins
  always_comb begin
    ev_next     = dzcpd_pkg::EV_NONE;
    xmem_next   = xmem;
    peak_next   = peak_value;
    trough_next = trough_value;
    if (cur_tap > 0 && old_tap <= 0) begin
      ev_next   = dzcpd_pkg::EV_UP;
      xmem_next = dzcpd_pkg::XM_UP;
    end else if (cur_tap < 0 && old_tap >= 0) begin
      ev_next   = dzcpd_pkg::EV_DOWN;
      xmem_next = dzcpd_pkg::XM_DOWN;
    end else if (xmem == dzcpd_pkg::XM_UP && cur_tap < old_tap) begin
      ev_next   = dzcpd_pkg::EV_PEAK;
      peak_next = old_tap;
      xmem_next = dzcpd_pkg::XM_NONE;
    end else if (xmem == dzcpd_pkg::XM_DOWN && cur_tap > old_tap) begin
      ev_next     = dzcpd_pkg::EV_TROUGH;
      trough_next = old_tap;
      xmem_next   = dzcpd_pkg::XM_NONE;
    end
  end

  // Tracking state advances once per classified sample
  always_ff @(posedge clk) begin
    if (rst) begin
      xmem         <= dzcpd_pkg::XM_NONE;
      peak_value   <= '0;
      trough_value <= '0;
    end else if (take) begin
      xmem         <= xmem_next;
      peak_value   <= peak_next;
      trough_value <= trough_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tap_ready) begin
      out_valid <= tap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ev             <= ev_next;
      delayed_sample <= cur_tap;
    end
  end

  assign event_res   = 3'(ev);
  assign last_peak   = peak_value;
  assign last_trough = trough_value;

  `DZCPD_ASSERT_NEXT(a_peak_capture, clk, rst, take && ev_next == dzcpd_pkg::EV_PEAK, peak_value == $past(old_tap) && xmem == dzcpd_pkg::XM_NONE)
  `DZCPD_ASSERT_NEXT(a_trough_capture, clk, rst, take && ev_next == dzcpd_pkg::EV_TROUGH, trough_value == $past(old_tap) && xmem == dzcpd_pkg::XM_NONE)
  `DZCPD_ASSERT_IMPLY(a_up_positive, clk, rst, out_valid && ev == dzcpd_pkg::EV_UP, delayed_sample > 0)

endmodule

// ===== design/delayed_zero_cross_peak_detector.sv =====
// Delayed zero-crossing and peak detector. Each transfer on the input
// channel pushes one signed Q2.13 sample into a shift line of HistoryDepth
// cells (cleared by reset); the tap at tap_delay (0 = newest, clamped to
// HistoryDepth - 2) is compared with the tap one older and classified as an
// upward or downward zero crossing, a peak or trough after a crossing, or
// nothing. One result comes out per sample and a new sample is taken every
// cycle while in_stall is low: the shift line, the registered tap pair and the
// classifier form a three-stage pipeline with its own valid bit per stage. A
// sample passes through the shift line, the tap pair register and the output
// register in that order. A stalled result holds the output register; the
// input keeps taking samples until both earlier stages are full behind it,
// and then stalls until the output transfer completes. tap_delay is always
// ready and should only be written while no sample is in flight.
`include "delayed_zero_cross_peak_detector_assert.svh"

module delayed_zero_cross_peak_detector #(
  parameter int HistoryDepth = dzcpd_pkg::HISTORY_DEPTH,
  parameter int SampleBits   = dzcpd_pkg::SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic        [dzcpd_pkg::TAP_BITS-1:0] tap_delay,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SampleBits-1:0]       sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [2:0]                  event_res,
  output logic signed [SampleBits-1:0]       delayed_sample,
  output logic signed [SampleBits-1:0]       last_peak,
  output logic signed [SampleBits-1:0]       last_trough
);

  localparam int              IdxW   = $clog2(HistoryDepth);
  localparam logic [IdxW-1:0] MaxTap = IdxW'(HistoryDepth - 2);

  logic        [IdxW-1:0]       tap_sel;
  logic signed [SampleBits-1:0] cell_q   [HistoryDepth];
  logic signed [SampleBits-1:0] cell_cur [HistoryDepth];
  logic signed [SampleBits-1:0] cell_old [HistoryDepth];
  logic signed [SampleBits-1:0] cur_or;
  logic signed [SampleBits-1:0] old_or;
  logic signed [SampleBits-1:0] cur_tap;
  logic signed [SampleBits-1:0] old_tap;
  logic                         v1;
  logic                         v2;
  logic                         tap_ready;
  logic                         move1;
  logic                         accept;

  // Tap delay register, clamped on write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_sel <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (32'(tap_delay) > 32'(HistoryDepth - 2)) begin
        tap_sel <= MaxTap;
      end else begin
        tap_sel <= IdxW'(tap_delay);
      end
    end
  end

  // Pipeline handshake: each stage advances when the next one frees up
  assign move1    = v1 && (!v2 || tap_ready);
  assign in_stall = v1 && !(!v2 || tap_ready);
  assign accept   = in_valid && !in_stall;

  // Shift line of history cells
  for (genvar i = 0; i < HistoryDepth; i++) begin : g_cell
    if (i == 0) begin : g_head
      dzcpd_cell #(
        .SampleBits (SampleBits),
        .IdxW       (IdxW),
        .CellIndex  (i)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (accept),
        .din      (sample),
        .tap_sel  (tap_sel),
        .q        (cell_q[i]),
        .cur_part (cell_cur[i]),
        .old_part (cell_old[i])
      );
    end else begin : g_body
      dzcpd_cell #(
        .SampleBits (SampleBits),
        .IdxW       (IdxW),
        .CellIndex  (i)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (accept),
        .din      (cell_q[i-1]),
        .tap_sel  (tap_sel),
        .q        (cell_q[i]),
        .cur_part (cell_cur[i]),
        .old_part (cell_old[i])
      );
    end
  end

  // Merge the one-hot tap outputs
  always_comb begin
    cur_or = '0;
    old_or = '0;
    for (int i = 0; i < HistoryDepth; i++) begin
      cur_or = cur_or | cell_cur[i];
      old_or = old_or | cell_old[i];
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (move1) begin
        v1 <= 1'b0;
      end
      if (move1) begin
        v2 <= 1'b1;
      end else if (tap_ready) begin
        v2 <= 1'b0;
      end
    end
  end

  // Register the selected tap pair
  always_ff @(posedge clk) begin
    if (move1) begin
      cur_tap <= cur_or;
      old_tap <= old_or;
    end
  end

  dzcpd_classify #(
    .SampleBits (SampleBits)
  ) u_classify (
    .clk            (clk),
    .rst            (rst),
    .tap_valid      (v2),
    .tap_ready      (tap_ready),
    .cur_tap        (cur_tap),
    .old_tap        (old_tap),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_res      (event_res),
    .delayed_sample (delayed_sample),
    .last_peak      (last_peak),
    .last_trough    (last_trough)
  );

  `DZCPD_ASSERT_NEXT(a_accept_fills_stage, clk, rst, accept, v1)
  `DZCPD_ASSERT_NEXT(a_tap_pair_loaded, clk, rst, move1, v2 && cur_tap == $past(cur_or))

endmodule
